// File: hw/rtl/bsmt_pkg.sv
`default_nettype none

package bsmt_pkg;

	// Operation codes carried on the request's tuser; code 3 acts as a query.
	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_REMOVE = 2'd1,
		MODE_QUERY  = 2'd2
	} mode_t;

	// Write controls broadcast from the sequencer to every cell.
	typedef struct packed {
		logic ins_new;  // write the request value into the first free cell
		logic rem_hit;  // the matching cell takes over the last live entry
	} cell_ctl_t;

	localparam int unsigned OUT_COUNT_WIDTH = 6;

endpackage

`default_nettype wire

// File: hw/rtl/bsmt_cell.sv
`default_nettype none

module bsmt_cell
	import bsmt_pkg::*;
#(
	parameter int unsigned VALUE_WIDTH = 32,
	parameter int unsigned CNT_WIDTH   = 6,
	parameter int unsigned INDEX       = 0
) (
	input  wire logic                   clk,
	input  wire logic [CNT_WIDTH-1:0]   occ,
	input  wire logic [VALUE_WIDTH-1:0] req_value,
	input  wire logic [VALUE_WIDTH-1:0] last_value,
	input  wire cell_ctl_t              ctl,
	output logic                        hit,
	output logic [VALUE_WIDTH-1:0]      entry
);

	localparam logic [CNT_WIDTH-1:0] IDX = CNT_WIDTH'(INDEX);

	logic [VALUE_WIDTH-1:0] entry_q;
	logic                   live;
	logic                   is_free_head;

	// A cell is live while its index lies below the occupancy.
	assign live         = IDX < occ;
	assign is_free_head = IDX == occ;
	assign hit          = live && (entry_q == req_value);
	assign entry        = entry_q;

	// Entry update: a new member lands in the first free cell, and a removed
	// member is overwritten by the last live entry.
	always_ff @(posedge clk) begin
		if (ctl.ins_new && is_free_head) begin
			entry_q <= req_value;
		end else if (ctl.rem_hit && hit) begin
			entry_q <= last_value;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/bounded_set_membership_table.sv
`default_nettype none
// Bounded set membership table: a set of up to SET_CAPACITY distinct values.
// Requests arrive on the s_ channel: s_tuser carries the operation (insert,
// remove or query; the unused code acts as a query) and s_tdata the value,
// of which the low VALUE_WIDTH bits are compared.
// Each request produces exactly one result on the m_ channel: whether the
// value was a member before the request, the member count after it, and
// whether an insert of a new value was refused because the set was full.
// A taken request is held until the output register can take its result;
// then every cell compares its entry against the value in parallel and the
// row is updated, and the result is registered at the end of that cycle.
// A new request is not accepted while one is held, since the cell row
// evaluates one request at a time.
// Reset empties the set at once; the cell contents are not cleared, as only
// cells below the member count are ever compared.
// When the receiver stalls, the result stays in the output register; one
// more request may be accepted, and it waits until the result is taken.
module bounded_set_membership_table
	import bsmt_pkg::*;
#(
	parameter int unsigned SET_CAPACITY = 32,
	parameter int unsigned VALUE_WIDTH  = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [31:0] entry_value
	input  wire logic [1:0]  s_tuser,   // [1:0] mode
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata    // [0] was_present, [6:1] member_count, [7] full_reject
);

	localparam int unsigned CNT_WIDTH = $clog2(SET_CAPACITY + 1);
	localparam int unsigned IDX_WIDTH = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;
	localparam logic [CNT_WIDTH-1:0] CAP = CNT_WIDTH'(SET_CAPACITY);
	localparam logic [CNT_WIDTH-1:0] ONE = CNT_WIDTH'(1);

	logic                    busy_q;
	mode_t                   mode_q;
	logic [VALUE_WIDTH-1:0]  value_q;
	logic [CNT_WIDTH-1:0]    occ_q;
	logic                    out_valid_q;
	logic                    was_present_q;
	logic [OUT_COUNT_WIDTH-1:0] count_q;
	logic                    reject_q;

	logic [SET_CAPACITY-1:0] hits;
	logic [VALUE_WIDTH-1:0]  entries [SET_CAPACITY];
	logic [VALUE_WIDTH-1:0]  last_value;
	logic [IDX_WIDTH-1:0]    last_idx;
	logic                    any_hit;
	logic                    is_full;
	logic                    commit;
	logic                    do_insert;
	logic                    do_remove;
	logic                    do_reject;
	logic [CNT_WIDTH-1:0]    occ_next;
	cell_ctl_t               ctl;

	assign s_tready = !busy_q;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {reject_q, count_q, was_present_q};

	// The held request is resolved once the output register can take its result.
	assign commit  = busy_q && (!out_valid_q || m_tready);
	assign any_hit = |hits;
	assign is_full = occ_q == CAP;

	// The last live entry is the one that refills a freed cell.
	assign last_idx   = IDX_WIDTH'(occ_q - ONE);
	assign last_value = entries[last_idx];

	// Operation decode; any code other than insert or remove changes nothing.
	always_comb begin
		do_insert = 1'b0;
		do_remove = 1'b0;
		do_reject = 1'b0;
		unique case (mode_q)
			MODE_INSERT: begin
				do_insert = !any_hit && !is_full;
				do_reject = !any_hit && is_full;
			end
			MODE_REMOVE: begin
				do_remove = any_hit;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		occ_next = occ_q;
		if (do_insert) begin
			occ_next = occ_q + ONE;
		end else if (do_remove) begin
			occ_next = occ_q - ONE;
		end
	end

	assign ctl.ins_new = commit && do_insert;
	assign ctl.rem_hit = commit && do_remove;

	// Row of cells, each holding one entry and comparing it against the request.
	for (genvar gi = 0; gi < SET_CAPACITY; gi++) begin : g_cell
		bsmt_cell #(
			.VALUE_WIDTH(VALUE_WIDTH),
			.CNT_WIDTH  (CNT_WIDTH),
			.INDEX      (gi)
		) u_cell (
			.clk       (clk),
			.occ       (occ_q),
			.req_value (value_q),
			.last_value(last_value),
			.ctl       (ctl),
			.hit       (hits[gi]),
			.entry     (entries[gi])
		);
	end

	// Request capture and sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			occ_q  <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				busy_q <= 1'b1;
			end else if (commit) begin
				busy_q <= 1'b0;
			end
			if (commit) begin
				occ_q <= occ_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			mode_q  <= mode_t'(s_tuser);
			value_q <= VALUE_WIDTH'(s_tdata);
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			was_present_q <= any_hit;
			count_q       <= OUT_COUNT_WIDTH'(occ_next);
			reject_q      <= do_reject;
		end
	end

	// The member count never exceeds the capacity.
	assert property (@(posedge clk) disable iff (!arst_n) occ_q <= CAP)
		else $error("member count above capacity");

	// Members are distinct, so at most one cell matches a request.
	assert property (@(posedge clk) disable iff (!arst_n) busy_q |-> $onehot0(hits))
		else $error("more than one cell matches the request");

	// A resolved request always leaves a result in the output register.
	assert property (@(posedge clk) disable iff (!arst_n) commit |=> out_valid_q)
		else $error("resolved request produced no result");

	// A refused insert concerns a value that was absent from a full set.
	assert property (@(posedge clk) disable iff (!arst_n)
		(commit && do_reject) |=> (!was_present_q && occ_q == CAP))
		else $error("reject flagged for a present value or a set that is not full");

endmodule

`default_nettype wire

// File: bench/membership_monitor.sv
`timescale 1ns / 100ps

module membership_monitor
	import bsmt_pkg::*;
#(
	parameter int unsigned SET_CAPACITY = 32,
	parameter int unsigned VALUE_WIDTH  = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [31:0] s_tdata,   // [31:0] entry_value
	input  wire logic [1:0]  s_tuser,   // [1:0] mode
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [7:0]  m_tdata,   // [0] was_present, [6:1] member_count, [7] full_reject
	output int               mismatches,
	output int               outstanding
);

	// One result as the block should report it.
	typedef struct packed {
		logic                       was_present;
		logic [OUT_COUNT_WIDTH-1:0] member_count;
		logic                       full_reject;
	} outcome_t;

	// Shadow copy of the set: only slots below live_members hold members.
	logic [VALUE_WIDTH-1:0] shadow_slot [SET_CAPACITY];
	int unsigned            live_members = 0;
	outcome_t               owed_outcomes [$];
	int                     fault_tally = 0;

	assign mismatches  = fault_tally;
	assign outstanding = owed_outcomes.size();

	// Applies one request to the shadow set and returns the result it must produce.
	function automatic outcome_t apply_to_shadow_set(logic [1:0] op, logic [31:0] raw_value);
		logic [VALUE_WIDTH-1:0] key;
		int                     found_at;
		outcome_t               res;
		key      = raw_value[VALUE_WIDTH-1:0];
		found_at = -1;
		for (int i = 0; i < int'(live_members); i++) begin
			if (found_at < 0 && shadow_slot[i] == key) begin
				found_at = i;
			end
		end
		res.full_reject = 1'b0;
		if (op == MODE_INSERT) begin
			if (found_at < 0) begin
				if (live_members < SET_CAPACITY) begin
					shadow_slot[live_members] = key;
					live_members++;
				end else begin
					res.full_reject = 1'b1;
				end
			end
		end else if (op == MODE_REMOVE) begin
			// The last live entry fills the hole left by the removed one.
			if (found_at >= 0) begin
				shadow_slot[found_at] = shadow_slot[live_members-1];
				live_members--;
			end
		end
		res.was_present  = (found_at >= 0);
		res.member_count = OUT_COUNT_WIDTH'(live_members);
		return res;
	endfunction

	// Results are matched before requests, so a result and a request taken at the
	// same edge never pair with each other.
	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		outcome_t got;
		if (!arst_n) begin
			owed_outcomes.delete();
			live_members = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.was_present  = m_tdata[0];
				got.member_count = m_tdata[6:1];
				got.full_reject  = m_tdata[7];
				if (owed_outcomes.size() == 0) begin
					$error("result %h arrived with no request outstanding", m_tdata);
					fault_tally++;
				end else begin
					want = owed_outcomes.pop_front();
					if (got.was_present !== want.was_present) begin
						$error("was_present: expected %0d, got %0d",
							want.was_present, got.was_present);
						fault_tally++;
					end
					if (got.member_count !== want.member_count) begin
						$error("member_count: expected %0d, got %0d",
							want.member_count, got.member_count);
						fault_tally++;
					end
					if (got.full_reject !== want.full_reject) begin
						$error("full_reject: expected %0d, got %0d",
							want.full_reject, got.full_reject);
						fault_tally++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				owed_outcomes.push_back(apply_to_shadow_set(s_tuser, s_tdata));
			end
		end
	end

endmodule

// File: bench/tb_bounded_set_membership_table.sv
`timescale 1ns / 100ps

module tb_bounded_set_membership_table;
	import bsmt_pkg::*;

	localparam logic [1:0]  MODE_UNUSED  = 2'd3;
	localparam int unsigned RANDOM_ITEMS = 1500;
	localparam int unsigned DRAIN_LIMIT  = 20000;

	typedef enum logic [1:0] {
		PHASE_FILL,
		PHASE_DRAIN,
		PHASE_MIXED
	} phase_t;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;
	logic [1:0]  s_tuser  = MODE_QUERY;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	int          mismatches;
	int          outstanding;
	bit          quiet    = 1'b0;
	int unsigned hold_left = 0;

	bounded_set_membership_table u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	membership_monitor u_monitor (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Mostly short pauses, now and then a long one.
	function automatic int unsigned idle_cycles();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(6, 30);
	endfunction

	// The receiver stalls at random, except during quiet stretches.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			m_tready  <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			m_tready <= 1'b1;
			if (!quiet && $urandom_range(0, 2) == 0) begin
				hold_left <= idle_cycles();
			end
		end
	end

	// Presents one request and returns at the edge where it is taken; valid stays
	// high afterwards so that back-to-back requests need no gap.
	task automatic send_request(input logic [1:0] op, input logic [31:0] value);
		int unsigned gap;
		gap = quiet ? 0 : idle_cycles();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= value;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	initial begin
		logic [31:0] pool [$];
		logic [31:0] seed_value;
		logic [31:0] value;
		logic [1:0]  op;
		phase_t      phase;
		int unsigned sent;
		int unsigned phase_len;
		int unsigned pool_size;
		int unsigned insert_pct;
		int unsigned remove_pct;
		int unsigned r;
		int unsigned waited;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty set, duplicates, extreme values, the unused code and removal with a
		// moved last entry.
		send_request(MODE_QUERY, 32'h0000_0000);
		send_request(MODE_REMOVE, 32'h0000_0000);
		send_request(MODE_INSERT, 32'h0000_0000);
		send_request(MODE_INSERT, 32'h0000_0000);
		send_request(MODE_INSERT, 32'hFFFF_FFFF);
		send_request(MODE_QUERY, 32'hFFFF_FFFF);
		send_request(MODE_UNUSED, 32'hFFFF_FFFF);
		send_request(MODE_UNUSED, 32'h1234_5678);
		send_request(MODE_INSERT, 32'h7FFF_FFFF);
		send_request(MODE_INSERT, 32'h8000_0000);
		send_request(MODE_REMOVE, 32'h0000_0000);
		send_request(MODE_QUERY, 32'h8000_0000);
		send_request(MODE_QUERY, 32'h0000_0000);
		send_request(MODE_REMOVE, 32'h0000_0000);
		send_request(MODE_REMOVE, 32'hFFFF_FFFF);
		send_request(MODE_REMOVE, 32'h8000_0000);
		send_request(MODE_REMOVE, 32'h7FFF_FFFF);
		send_request(MODE_QUERY, 32'h7FFF_FFFF);
		send_request(MODE_INSERT, 32'hA5A5_A5A5);
		send_request(MODE_INSERT, 32'h5A5A_5A5A);

		// Random phases over a value pool: large pools drive the set to full,
		// small ones keep it churning, and drain phases empty it again.
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			phase     = phase_t'($urandom_range(0, 2));
			quiet     = ($urandom_range(0, 4) == 0);
			pool_size = ($urandom_range(0, 9) < 6) ? $urandom_range(34, 44)
				: $urandom_range(4, 20);
			phase_len = $urandom_range(40, 120);
			pool.delete();
			seed_value = $urandom();
			for (int i = 0; i < int'(pool_size); i++) begin
				// Some members differ from one another in a single bit.
				if ($urandom_range(0, 3) == 0) begin
					pool.push_back(seed_value ^ (32'd1 << $urandom_range(0, 31)));
				end else begin
					pool.push_back($urandom());
				end
			end
			if ($urandom_range(0, 3) == 0) pool.push_back(32'h0000_0000);
			if ($urandom_range(0, 3) == 0) pool.push_back(32'hFFFF_FFFF);
			case (phase)
				PHASE_FILL: begin
					insert_pct = 65;
					remove_pct = 15;
				end
				PHASE_DRAIN: begin
					insert_pct = 15;
					remove_pct = 65;
				end
				default: begin
					insert_pct = 35;
					remove_pct = 35;
				end
			endcase
			for (int k = 0; k < int'(phase_len) && sent < RANDOM_ITEMS; k++) begin
				r = $urandom_range(0, 99);
				if (r < insert_pct) begin
					op = MODE_INSERT;
				end else if (r < insert_pct + remove_pct) begin
					op = MODE_REMOVE;
				end else if ($urandom_range(0, 4) == 0) begin
					op = MODE_UNUSED;
				end else begin
					op = MODE_QUERY;
				end
				if ($urandom_range(0, 9) == 0) begin
					value = $urandom();
				end else begin
					value = pool[$urandom_range(0, pool.size() - 1)];
				end
				send_request(op, value);
				sent++;
			end
		end
		s_tvalid <= 1'b0;
		quiet    = 1'b0;

		// Let the last results drain, then allow a few cycles for stray output.
		waited = 0;
		while (outstanding != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);

		if (mismatches == 0 && outstanding == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// Hard stop well beyond the slowest legitimate run.
	initial begin
		#10_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
